// ===== rtl/core/cabs_pkg.sv =====
// cabs_pkg: request/result types, action and status codes for the
// compact element store with bound search. No dependencies.
package cabs_pkg;

  localparam logic [2:0] ACT_PUSH        = 3'd0;
  localparam logic [2:0] ACT_POP         = 3'd1;
  localparam logic [2:0] ACT_GET         = 3'd2;
  localparam logic [2:0] ACT_SWAP_REMOVE = 3'd3;
  localparam logic [2:0] ACT_LOWER_BOUND = 3'd4;
  localparam logic [2:0] ACT_UPPER_BOUND = 3'd5;
  localparam logic [2:0] ACT_FIND        = 3'd6;

  localparam logic [1:0] STS_OK   = 2'd0;
  localparam logic [1:0] STS_MISS = 2'd1;
  localparam logic [1:0] STS_FULL = 2'd2;

  typedef struct packed {
    logic [2:0]  action;
    logic [9:0]  index;
    logic [31:0] element_in;
    logic [31:0] search_key;
  } cabs_req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] element_out;
    logic [10:0] position;
    logic [10:0] count;
  } cabs_rsp_t;

endpackage

// ===== rtl/core/compact_array_with_bound_search.sv =====
// compact_array_with_bound_search: element store with fill count, push/pop/get/
// swap-remove and binary lower/upper bound and find under a small sequencer.
// Depends on cabs_pkg and cabs_ram.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+-----------
//   in      | in        | in_valid / in_ready  | cabs_req_t
//   out     | out       | out_valid / out_ready| cabs_rsp_t
//   cfg     | in        | cfg_wr_en            | compare_signed
//
// One request at a time; in_ready is high only while the sequencer is idle.
// Push, bad index, empty pop and unknown actions go from dispatch to done;
// pop, get and swap-remove wait on one RAM read. A search spends a search and
// a compare state per halving step on the single read port; find adds a read.
// The result sits in an output register, so a stalled out side only holds the
// sequencer in its last state. Reset clears the fill count; no clearing pass.
module compact_array_with_bound_search
  import cabs_pkg::*;
#(
  parameter int DEPTH         = 1024,
  parameter int ELEMENT_WIDTH = 32
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  cabs_req_t in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output cabs_rsp_t out_data,
  input  logic      cfg_wr_en,
  input  logic      cfg_wr_data
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int EW = ELEMENT_WIDTH;

  typedef enum logic [6:0] {
    S_IDLE     = 7'b0000001,
    S_DISPATCH = 7'b0000010,
    S_RDWAIT   = 7'b0000100,
    S_SEARCH   = 7'b0001000,
    S_CMP      = 7'b0010000,
    S_FINDWAIT = 7'b0100000,
    S_DONE     = 7'b1000000
  } state_t;

  state_t         state_r, state_nxt;
  cabs_req_t      req_r, req_nxt;
  logic [CW-1:0]  count_r, count_nxt;
  logic [CW-1:0]  first_r, first_nxt;
  logic [CW-1:0]  span_r, span_nxt;
  logic           cmp_signed_r;
  logic [1:0]     res_status_r, res_status_nxt;
  logic [EW-1:0]  res_elem_r, res_elem_nxt;
  logic [CW-1:0]  res_pos_r, res_pos_nxt;
  logic           out_valid_r, out_valid_nxt;
  cabs_rsp_t      out_data_r, out_data_nxt;

  logic           ram_wr_en;
  logic [AW-1:0]  ram_wr_addr;
  logic [EW-1:0]  ram_wr_data;
  logic           ram_rd_en;
  logic [AW-1:0]  ram_rd_addr;
  logic [EW-1:0]  ram_rd_data;

  logic [63:0]    elem_ext, key_ext, res_elem_ext;
  logic [31:0]    idx_ext, cnt_ext, last_ext, mid_ext, first_ext, res_pos_ext;
  logic [EW-1:0]  sign_flip, key_ord, elem_ord;
  logic [CW-1:0]  half, mid, last;
  logic           idx_ok, go_right;

  cabs_ram #(
    .WIDTH(EW),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk    (clk),
    .wr_en  (ram_wr_en),
    .wr_addr(ram_wr_addr),
    .wr_data(ram_wr_data),
    .rd_en  (ram_rd_en),
    .rd_addr(ram_rd_addr),
    .rd_data(ram_rd_data)
  );

  // Operand shaping
  always_comb begin
    elem_ext    = 64'(req_r.element_in);
    key_ext     = 64'(req_r.search_key);
    sign_flip   = EW'(cmp_signed_r) << (EW - 1);
    key_ord     = key_ext[EW-1:0] ^ sign_flip;
    elem_ord    = ram_rd_data ^ sign_flip;
    half        = span_r >> 1;
    mid         = first_r + half;
    last        = count_r - 1'b1;
    idx_ext     = 32'(req_r.index);
    cnt_ext     = 32'(count_r);
    last_ext    = 32'(last);
    mid_ext     = 32'(mid);
    first_ext   = 32'(first_r);
    idx_ok      = idx_ext < cnt_ext;
    go_right    = (req_r.action == ACT_UPPER_BOUND) ? (key_ord >= elem_ord)
                                                    : (elem_ord < key_ord);
    res_elem_ext = 64'(res_elem_r);
    res_pos_ext  = 32'(res_pos_r);
  end

  always_comb begin
    state_nxt      = state_r;
    req_nxt        = req_r;
    count_nxt      = count_r;
    first_nxt      = first_r;
    span_nxt       = span_r;
    res_status_nxt = res_status_r;
    res_elem_nxt   = res_elem_r;
    res_pos_nxt    = res_pos_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_data_nxt   = out_data_r;
    ram_wr_en      = 1'b0;
    ram_wr_addr    = idx_ext[AW-1:0];
    ram_wr_data    = ram_rd_data;
    ram_rd_en      = 1'b0;
    ram_rd_addr    = mid_ext[AW-1:0];

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          req_nxt   = in_data;
          state_nxt = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        res_status_nxt = STS_OK;
        res_elem_nxt   = '0;
        res_pos_nxt    = '0;
        first_nxt      = '0;
        span_nxt       = count_r;
        state_nxt      = S_DONE;
        unique case (req_r.action)
          ACT_PUSH: begin
            if (cnt_ext == 32'(DEPTH)) begin
              res_status_nxt = STS_FULL;
            end else begin
              ram_wr_en   = 1'b1;
              ram_wr_addr = cnt_ext[AW-1:0];
              ram_wr_data = elem_ext[EW-1:0];
              count_nxt   = count_r + 1'b1;
            end
          end
          ACT_POP: begin
            if (count_r == '0) begin
              res_status_nxt = STS_MISS;
            end else begin
              ram_rd_en   = 1'b1;
              ram_rd_addr = last_ext[AW-1:0];
              count_nxt   = last;
              state_nxt   = S_RDWAIT;
            end
          end
          ACT_GET: begin
            if (!idx_ok) begin
              res_status_nxt = STS_MISS;
            end else begin
              ram_rd_en   = 1'b1;
              ram_rd_addr = idx_ext[AW-1:0];
              state_nxt   = S_RDWAIT;
            end
          end
          ACT_SWAP_REMOVE: begin
            if (!idx_ok) begin
              res_status_nxt = STS_MISS;
            end else begin
              ram_rd_en   = 1'b1;
              ram_rd_addr = last_ext[AW-1:0];
              count_nxt   = last;
              state_nxt   = S_RDWAIT;
            end
          end
          ACT_LOWER_BOUND, ACT_UPPER_BOUND, ACT_FIND: begin
            state_nxt = S_SEARCH;
          end
          default: begin
            res_status_nxt = STS_MISS;
          end
        endcase
      end
      S_RDWAIT: begin
        res_elem_nxt = ram_rd_data;
        // swap-remove: last element lands in the removed slot
        if (req_r.action == ACT_SWAP_REMOVE) begin
          ram_wr_en = 1'b1;
        end
        state_nxt = S_DONE;
      end
      S_SEARCH: begin
        if (span_r != '0) begin
          ram_rd_en = 1'b1;
          state_nxt = S_CMP;
        end else if (req_r.action == ACT_FIND && first_r < count_r) begin
          ram_rd_en   = 1'b1;
          ram_rd_addr = first_ext[AW-1:0];
          state_nxt   = S_FINDWAIT;
        end else if (req_r.action == ACT_FIND) begin
          res_pos_nxt    = count_r;
          res_status_nxt = STS_MISS;
          state_nxt      = S_DONE;
        end else begin
          res_pos_nxt = first_r;
          state_nxt   = S_DONE;
        end
      end
      S_CMP: begin
        if (go_right) begin
          first_nxt = mid + 1'b1;
          span_nxt  = span_r - half - 1'b1;
        end else begin
          span_nxt  = half;
        end
        state_nxt = S_SEARCH;
      end
      S_FINDWAIT: begin
        if (elem_ord == key_ord) begin
          res_pos_nxt = first_r;
        end else begin
          res_pos_nxt    = count_r;
          res_status_nxt = STS_MISS;
        end
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt            = 1'b1;
          out_data_nxt.status      = res_status_r;
          out_data_nxt.element_out = res_elem_ext[31:0];
          out_data_nxt.position    = res_pos_ext[10:0];
          out_data_nxt.count       = cnt_ext[10:0];
          state_nxt                = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      count_r      <= '0;
      cmp_signed_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        cmp_signed_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    req_r        <= req_nxt;
    first_r      <= first_nxt;
    span_r       <= span_nxt;
    res_status_r <= res_status_nxt;
    res_elem_r   <= res_elem_nxt;
    res_pos_r    <= res_pos_nxt;
    out_data_r   <= out_data_nxt;
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(count_r) <= 32'(DEPTH))
    else $error("fill count above depth");

  a_wr_states: assert property (@(posedge clk) disable iff (!rst_n)
    ram_wr_en |-> (state_r == S_DISPATCH || state_r == S_RDWAIT))
    else $error("store written outside push or swap-remove");

  a_search_window: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SEARCH || state_r == S_CMP) |->
      (32'(first_r) + 32'(span_r) <= 32'(count_r)))
    else $error("search window beyond fill count");

  a_req_dispatch: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == S_DISPATCH))
    else $error("accepted request not dispatched");

  a_rsp_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == S_DONE))
    else $error("result raised outside done state");
`endif

endmodule

// ===== rtl/core/cabs_ram.sv =====
// cabs_ram: generic simple dual-port RAM, one write and one registered read
// per cycle. No dependencies.
module cabs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
